/* src/assert_macros.svh */
// Assertion macros for the sorted key table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define SKT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SKT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/skt_pkg.sv */
// Shared constants, codes and control structs of the sorted key table.
package skt_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;

    localparam int REQ_W     = 2;
    localparam int KEYIN_W   = 32;
    localparam int HANDLE_W  = 32;
    localparam int RUNTIME_W = 16;
    localparam int DISP_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 8;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OOR      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;       // take a request word this cycle if offered
        logic srch_read;   // read key and slot at the next midpoint
        logic srch_cmp;    // narrow the search window
        logic hit;         // rewrite the matched slot, stage "updated"
        logic full_res;    // stage "full"
        logic shift_init;  // point the shift at the entry count
        logic shift_step;  // move one entry up
        logic place;       // write the new key and slot, bump the count
        logic look_res;    // stage the lookup result
        logic oor_res;     // stage "out of range"
        logic clr_step;    // zero one slot
        logic clr_res;     // stage "cleared"
        logic push;        // move the staged result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             in_valid;
        logic [REQ_W-1:0] req;
        logic             open;       // search window not empty
        logic             key_eq;     // key matches the entry read
        logic             full;
        logic             oor;        // lookup index past the count
        logic             dst_gt_lo;  // more entries to shift
        logic             pend;       // shift write outstanding
        logic             clr_more;   // more slots to clear
        logic             out_free;   // output register can take a word
    } t_stat;

endpackage

/* src/skt_req_if.sv */
// Request channel: valid, ready and one request word.
interface skt_req_if;
    import skt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [KEYIN_W-1:0]   key;
    logic [HANDLE_W-1:0]  func_handle;
    logic [RUNTIME_W-1:0] rt_index;
    logic [DISP_W-1:0]    dispatch_index;

    modport source (
        output valid, req_type, key, func_handle, rt_index, dispatch_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, key, func_handle, rt_index, dispatch_index,
        output ready
    );
endinterface

/* src/skt_rsp_if.sv */
// Response channel: valid, ready and one result word.
interface skt_rsp_if;
    import skt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     sorted_position;
    logic [POS_W-1:0]     slot_index;
    logic [HANDLE_W-1:0]  handle_out;
    logic [RUNTIME_W-1:0] runtime_out;

    modport source (
        output valid, status, sorted_position, slot_index, handle_out, runtime_out,
        input  ready
    );
    modport sink (
        input  valid, status, sorted_position, slot_index, handle_out, runtime_out,
        output ready
    );
endinterface

/* src/skt_ram.sv */
// Generic simple dual-port RAM with registered read.
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/skt_ctrl.sv */
// Controller state machine of the sorted key table.
module skt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  skt_pkg::t_stat i_stat,
    output skt_pkg::t_cmd  o_cmd
);
    import skt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_MISS   = 4'd4;
    localparam logic [3:0] S_SHIFT  = 4'd5;
    localparam logic [3:0] S_LOOK   = 4'd6;
    localparam logic [3:0] S_CLR    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.req)
                    REQ_INSERT: n_state = S_SRCH;
                    REQ_LOOKUP: begin
                        if (i_stat.oor) begin
                            o_cmd.oor_res = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            n_state = S_LOOK;
                        end
                    end
                    REQ_CLEAR: n_state = S_CLR;
                    default:   n_state = S_IDLE;   // unknown request: drop
                endcase
            end
            S_SRCH: begin
                if (i_stat.open) begin
                    o_cmd.srch_read = 1'b1;
                    n_state         = S_CMP;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                if (i_stat.key_eq) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_MISS: begin
                if (i_stat.full) begin
                    o_cmd.full_res = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.dst_gt_lo || i_stat.pend) begin
                    o_cmd.shift_step = 1'b1;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_LOOK: begin
                o_cmd.look_res = 1'b1;
                n_state        = S_DONE;
            end
            S_CLR: begin
                if (i_stat.clr_more) begin
                    o_cmd.clr_step = 1'b1;
                end else begin
                    o_cmd.clr_res = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* src/skt_dp.sv */
// Datapath of the sorted key table: search window, shift pointer, stores, result.
`include "assert_macros.svh"

module skt_dp #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    skt_req_if.sink        i_req,
    skt_rsp_if.source      o_rsp,
    input  skt_pkg::t_cmd  i_cmd,
    output skt_pkg::t_stat o_stat
);
    import skt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > DISP_W) ? CNT_W : DISP_W;
    localparam int SLOT_DW = HANDLE_W + RUNTIME_W;

    // control state
    logic [CNT_W-1:0] r_count;
    logic             r_pend;
    logic             r_ov;

    // request and working registers
    logic [REQ_W-1:0]     r_req;
    logic [KEY_BITS-1:0]  r_key;
    logic [HANDLE_W-1:0]  r_handle;
    logic [RUNTIME_W-1:0] r_runtime;
    logic [DISP_W-1:0]    r_disp;
    logic [CNT_W-1:0]     r_lo;
    logic [CNT_W-1:0]     r_hi_ex;
    logic [IDX_W-1:0]     r_mid;
    logic [CNT_W-1:0]     r_ptr;
    logic [IDX_W-1:0]     r_wr_addr;

    // staged result and output register
    logic [STATUS_W-1:0]  r_res_st;
    logic [POS_W-1:0]     r_res_pos;
    logic [POS_W-1:0]     r_res_slot;
    logic [HANDLE_W-1:0]  r_res_h;
    logic [RUNTIME_W-1:0] r_res_r;
    logic [STATUS_W-1:0]  r_o_st;
    logic [POS_W-1:0]     r_o_pos;
    logic [POS_W-1:0]     r_o_slot;
    logic [HANDLE_W-1:0]  r_o_h;
    logic [RUNTIME_W-1:0] r_o_r;

    logic                 accept;
    logic [CNT_W:0]       mid_sum;
    logic [IDX_W-1:0]     mid_calc;
    logic                 key_lt;
    logic                 key_eq;

    logic                 key_we;
    logic [IDX_W-1:0]     key_waddr;
    logic [KEY_BITS-1:0]  key_wdata;
    logic [IDX_W-1:0]     slot_wdata;
    logic [IDX_W-1:0]     key_raddr;
    logic [KEY_BITS-1:0]  key_rd;
    logic [IDX_W-1:0]     slot_rd;

    logic                 hnd_we;
    logic [IDX_W-1:0]     hnd_waddr;
    logic [SLOT_DW-1:0]   hnd_wdata;
    logic [SLOT_DW-1:0]   hnd_rd;
    logic [HANDLE_W-1:0]  rd_handle;
    logic [RUNTIME_W-1:0] rd_runtime;

    // hold ready low while reset is asserted
    assign i_req.ready = i_cmd.ready && i_rst_n;
    assign accept      = i_req.valid && i_req.ready;

    // midpoint of the window [lo, hi_ex), floor of (lo + hi_ex - 1) / 2
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi_ex} - 1'b1;
    assign mid_calc = mid_sum[IDX_W:1];

    assign key_lt = r_key < key_rd;
    assign key_eq = r_key == key_rd;

    assign rd_handle  = hnd_rd[SLOT_DW-1:RUNTIME_W];
    assign rd_runtime = hnd_rd[RUNTIME_W-1:0];

    always_comb begin
        o_stat           = '0;
        o_stat.in_valid  = i_req.valid;
        o_stat.req       = r_req;
        o_stat.open      = r_lo < r_hi_ex;
        o_stat.key_eq    = key_eq;
        o_stat.full      = r_count == CNT_W'(CAPACITY);
        o_stat.oor       = CMP_W'(r_disp) >= CMP_W'(r_count);
        o_stat.dst_gt_lo = r_ptr > r_lo;
        o_stat.pend      = r_pend;
        o_stat.clr_more  = r_ptr < r_count;
        o_stat.out_free  = !r_ov || o_rsp.ready;
    end

    // key and slot store port selection
    always_comb begin
        key_we     = 1'b0;
        key_waddr  = r_wr_addr;
        key_wdata  = key_rd;
        slot_wdata = slot_rd;
        if (i_cmd.shift_step && r_pend) begin
            key_we = 1'b1;
        end else if (i_cmd.place) begin
            key_we     = 1'b1;
            key_waddr  = IDX_W'(r_lo);
            key_wdata  = r_key;
            slot_wdata = IDX_W'(r_count);
        end
        key_raddr = i_cmd.srch_read ? mid_calc : IDX_W'(r_ptr - 1'b1);
    end

    // dispatch slot store port selection
    always_comb begin
        hnd_we    = i_cmd.hit || i_cmd.place || i_cmd.clr_step;
        hnd_wdata = {r_handle, r_runtime};
        priority if (i_cmd.hit) begin
            hnd_waddr = slot_rd;
        end else if (i_cmd.place) begin
            hnd_waddr = IDX_W'(r_count);
        end else begin
            hnd_waddr = IDX_W'(r_ptr);
            hnd_wdata = '0;
        end
    end

    skt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rd)
    );

    skt_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (key_raddr),
        .o_rdata (slot_rd)
    );

    skt_ram #(.WIDTH(SLOT_DW), .DEPTH(CAPACITY)) u_hnd_ram (
        .i_clk   (i_clk),
        .i_we    (hnd_we),
        .i_waddr (hnd_waddr),
        .i_wdata (hnd_wdata),
        .i_raddr (IDX_W'(r_disp)),
        .o_rdata (hnd_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.place) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.shift_step) begin
                r_pend <= r_ptr > r_lo;
            end
            if (i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req.req_type;
            r_key     <= KEY_BITS'(i_req.key);
            r_handle  <= i_req.func_handle;
            r_runtime <= i_req.rt_index;
            r_disp    <= i_req.dispatch_index;
            r_lo      <= '0;
            r_hi_ex   <= r_count;
            r_ptr     <= '0;
        end
        if (i_cmd.srch_read) begin
            r_mid <= mid_calc;
        end
        if (i_cmd.srch_cmp && !key_eq) begin
            if (key_lt) begin
                r_hi_ex <= CNT_W'(r_mid);
            end else begin
                r_lo <= CNT_W'(r_mid) + 1'b1;
            end
        end
        if (i_cmd.shift_init) begin
            r_ptr <= r_count;
        end
        if (i_cmd.shift_step && (r_ptr > r_lo)) begin
            r_wr_addr <= IDX_W'(r_ptr);
            r_ptr     <= r_ptr - 1'b1;
        end
        if (i_cmd.clr_step) begin
            r_ptr <= r_ptr + 1'b1;
        end

        if (i_cmd.hit) begin
            r_res_st   <= ST_UPDATED;
            r_res_pos  <= POS_W'(r_mid);
            r_res_slot <= POS_W'(slot_rd);
            r_res_h    <= '0;
            r_res_r    <= '0;
        end else if (i_cmd.place) begin
            r_res_st   <= ST_INSERTED;
            r_res_pos  <= POS_W'(r_lo);
            r_res_slot <= POS_W'(r_count);
            r_res_h    <= '0;
            r_res_r    <= '0;
        end else if (i_cmd.full_res) begin
            r_res_st   <= ST_FULL;
            r_res_pos  <= '0;
            r_res_slot <= '0;
            r_res_h    <= '0;
            r_res_r    <= '0;
        end else if (i_cmd.oor_res) begin
            r_res_st   <= ST_OOR;
            r_res_pos  <= '0;
            r_res_slot <= r_disp;
            r_res_h    <= '0;
            r_res_r    <= '0;
        end else if (i_cmd.look_res) begin
            // an empty handle reads back as zero either way
            r_res_st   <= (rd_handle != '0) ? ST_HIT : ST_INACTIVE;
            r_res_pos  <= '0;
            r_res_slot <= r_disp;
            r_res_h    <= rd_handle;
            r_res_r    <= rd_runtime;
        end else if (i_cmd.clr_res) begin
            r_res_st   <= ST_CLEARED;
            r_res_pos  <= '0;
            r_res_slot <= '0;
            r_res_h    <= '0;
            r_res_r    <= '0;
        end

        if (i_cmd.push) begin
            r_o_st   <= r_res_st;
            r_o_pos  <= r_res_pos;
            r_o_slot <= r_res_slot;
            r_o_h    <= r_res_h;
            r_o_r    <= r_res_r;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.status          = r_o_st;
    assign o_rsp.sorted_position = r_o_pos;
    assign o_rsp.slot_index      = r_o_slot;
    assign o_rsp.handle_out      = r_o_h;
    assign o_rsp.runtime_out     = r_o_r;

    `SKT_ASSERT(a_place_bumps_count, i_clk, i_rst_n, i_cmd.place |=> (r_count == $past(r_count) + 1'b1), "place did not advance the entry count")
    `SKT_ASSERT(a_place_not_full, i_clk, i_rst_n, i_cmd.place |-> (r_count < CNT_W'(CAPACITY)), "insert placed into a full table")
    `SKT_ASSERT(a_push_free, i_clk, i_rst_n, i_cmd.push |-> (!r_ov || o_rsp.ready), "result pushed over a waiting word")
    `SKT_ASSERT(a_shift_above_lo, i_clk, i_rst_n, i_cmd.shift_step |-> (r_ptr >= r_lo), "shift pointer below insert position")
endmodule

/* src/sorted_key_table_stable_index.sv */
// Top level of the sorted key table with stable dispatch slots.
//
// Channels: i_req takes request words (insert/update a key, look up a
// dispatch slot, clear all slots); o_rsp returns exactly one result word
// for each request of a known type. Unknown request types are dropped.
// Requests are handled one at a time: i_req.ready is high only while the
// controller is idle, and a new request can be taken from the cycle after
// the previous result moves into the output register, so the next request
// can be taken while the previous result is still held on o_rsp.
// A lookup reads the dispatch slot store (an index at or past the entry
// count is answered as out of range without a read); a clear zeroes every
// slot below the entry count; an insert binary-searches the key store and,
// on a miss, shifts every larger key up one place unless the table is full.
// The shift moves one entry a cycle through the single write port of the
// key store; a clear zeroes one slot a cycle.
// Reset empties the table (entry count to zero) and drops any waiting result.
// When the receiver stalls, the result holds on o_rsp and the controller
// holds its finished result until the output register frees up.
module sorted_key_table_stable_index #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    skt_req_if.sink   i_req,
    skt_rsp_if.source o_rsp
);
    import skt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequence the search, shift, lookup and clear
    skt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // hold the stores, the search window and the result registers
    skt_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );
endmodule

/* sim/sorted_key_table_stable_index_test.sv */
// Self-checking testbench for the sorted key table with stable dispatch slots.
module sorted_key_table_stable_index_test;
    import skt_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int TABLE_DEPTH  = CAPACITY_DEF;
    // Cycle limit on the whole run; a correct run ends well before it.
    localparam int LIMIT_CYCLES = 4_000_000;
    // Longest single request (clear, or a miss that shifts a nearly full table) plus margin.
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
    // The block drops this request type without a reply.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [KEYIN_W-1:0]   key;
        logic [HANDLE_W-1:0]  func_handle;
        logic [RUNTIME_W-1:0] rt_index;
        logic [DISP_W-1:0]    dispatch_index;
    } t_table_request;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POS_W-1:0]     sorted_position;
        logic [POS_W-1:0]     slot_index;
        logic [HANDLE_W-1:0]  handle_out;
        logic [RUNTIME_W-1:0] runtime_out;
    } t_table_reply;

    logic i_clk;
    logic i_rst_n;

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table_stable_index i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the table: sorted keys, their slots, and the slot contents.
    logic [KEYIN_W-1:0]   key_tbl     [TABLE_DEPTH];
    logic [POS_W-1:0]     slot_tbl    [TABLE_DEPTH];
    logic [HANDLE_W-1:0]  handle_tbl  [TABLE_DEPTH];
    logic [RUNTIME_W-1:0] runtime_tbl [TABLE_DEPTH];
    int                   entry_count;

    t_table_reply pending_replies[$];
    t_table_reply want_reply;
    int           error_count;

    // Idle odds, in percent, for the request and the reply side.
    int send_idle_pct;
    int recv_idle_pct;
    // Cycles left in a forced reply stall; the receiver process counts it down.
    int rsp_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: take a reply word at random, or hold off while a stall is armed.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Check at the falling edge: valid, ready and the word are stable until the
    // rising edge that moves the word, whatever order the edge events take.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply word: expected none, actual status %0d",
                         $time, rsp_ch.status);
                error_count++;
            end else begin
                want_reply = pending_replies.pop_front();
                check_field("status", 32'(want_reply.status), 32'(rsp_ch.status));
                check_field("sorted_position", 32'(want_reply.sorted_position),
                            32'(rsp_ch.sorted_position));
                check_field("slot_index", 32'(want_reply.slot_index),
                            32'(rsp_ch.slot_index));
                check_field("handle_out", want_reply.handle_out, rsp_ch.handle_out);
                check_field("runtime_out", 32'(want_reply.runtime_out),
                            32'(rsp_ch.runtime_out));
            end
        end
    end

    // Update the shadow table for one accepted request and queue its reply.
    task automatic apply_request(input t_table_request rq);
        int           lo;
        int           hi;
        int           mid;
        int           i;
        bit           found;
        t_table_reply rp;
        rp    = '0;
        found = 1'b0;
        mid   = 0;
        case (rq.req_type)
            REQ_INSERT: begin
                lo = 0;
                hi = entry_count - 1;
                while (lo <= hi && !found) begin
                    mid = (lo + hi) / 2;
                    if (rq.key < key_tbl[mid]) begin
                        hi = mid - 1;
                    end else if (rq.key > key_tbl[mid]) begin
                        lo = mid + 1;
                    end else begin
                        found = 1'b1;
                    end
                end
                if (found) begin
                    // Key present: rewrite its slot, keep the slot number.
                    handle_tbl[slot_tbl[mid]]  = rq.func_handle;
                    runtime_tbl[slot_tbl[mid]] = rq.rt_index;
                    rp.status          = ST_UPDATED;
                    rp.sorted_position = POS_W'(mid);
                    rp.slot_index      = slot_tbl[mid];
                end else if (entry_count >= TABLE_DEPTH) begin
                    rp.status = ST_FULL;
                end else begin
                    // Key absent: shift larger keys up, take the next free slot.
                    for (i = entry_count - 1; i >= lo; i--) begin
                        key_tbl[i + 1]  = key_tbl[i];
                        slot_tbl[i + 1] = slot_tbl[i];
                    end
                    key_tbl[lo]              = rq.key;
                    slot_tbl[lo]             = POS_W'(entry_count);
                    handle_tbl[entry_count]  = rq.func_handle;
                    runtime_tbl[entry_count] = rq.rt_index;
                    rp.status          = ST_INSERTED;
                    rp.sorted_position = POS_W'(lo);
                    rp.slot_index      = POS_W'(entry_count);
                    entry_count++;
                end
                pending_replies.push_back(rp);
            end
            REQ_LOOKUP: begin
                rp.slot_index = rq.dispatch_index;
                if (int'(rq.dispatch_index) >= entry_count) begin
                    rp.status = ST_OOR;
                end else if (handle_tbl[rq.dispatch_index] != '0) begin
                    rp.status      = ST_HIT;
                    rp.handle_out  = handle_tbl[rq.dispatch_index];
                    rp.runtime_out = runtime_tbl[rq.dispatch_index];
                end else begin
                    rp.status      = ST_INACTIVE;
                    rp.runtime_out = runtime_tbl[rq.dispatch_index];
                end
                pending_replies.push_back(rp);
            end
            REQ_CLEAR: begin
                for (i = 0; i < entry_count; i++) begin
                    handle_tbl[i]  = '0;
                    runtime_tbl[i] = '0;
                end
                rp.status = ST_CLEARED;
                pending_replies.push_back(rp);
            end
            default: begin
            end
        endcase
    endtask

    // Offer one request word and hold it until the block takes it. Called in a
    // rising-edge step; returns in the step of the edge that moved the word.
    task automatic send_request(input t_table_request rq);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= rq.req_type;
        req_ch.key            <= rq.key;
        req_ch.func_handle    <= rq.func_handle;
        req_ch.rt_index       <= rq.rt_index;
        req_ch.dispatch_index <= rq.dispatch_index;
        // Sample ready at the falling edge, where it is stable.
        do begin
            @(negedge i_clk);
        end while (req_ch.ready !== 1'b1);
        @(posedge i_clk);
        apply_request(rq);
    endtask

    // Drop valid and wait until every queued reply has come back.
    task automatic idle_until_replies_done();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_replies.size() != 0);
    endtask

    function automatic t_table_request make_request(input logic [REQ_W-1:0] kind,
                                                    input logic [KEYIN_W-1:0] key,
                                                    input logic [HANDLE_W-1:0] handle,
                                                    input logic [RUNTIME_W-1:0] rt,
                                                    input logic [DISP_W-1:0] disp);
        t_table_request rq;
        rq.req_type       = kind;
        rq.key            = key;
        rq.func_handle    = handle;
        rq.rt_index       = rt;
        rq.dispatch_index = disp;
        return rq;
    endfunction

    function automatic bit key_present(input logic [KEYIN_W-1:0] key);
        for (int i = 0; i < entry_count; i++) begin
            if (key_tbl[i] == key) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mostly random keys; now and then the extremes or a neighbor of a stored key,
    // which lands right beside it in the sorted order.
    function automatic logic [KEYIN_W-1:0] fresh_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4) return '0;
        if (pick < 8) return '1;
        if (pick < 20 && entry_count > 0) begin
            if ($urandom_range(1) == 1)
                return key_tbl[$urandom_range(entry_count - 1)] + 32'd1;
            return key_tbl[$urandom_range(entry_count - 1)] - 32'd1;
        end
        return $urandom();
    endfunction

    function automatic logic [HANDLE_W-1:0] random_handle();
        if ($urandom_range(99) < 15) return '0;
        return $urandom();
    endfunction

    task automatic send_random_request();
        int             pick;
        t_table_request rq;
        pick = $urandom_range(99);
        rq = make_request(REQ_INSERT, $urandom(), random_handle(),
                          RUNTIME_W'($urandom_range(16'hFFFF)),
                          DISP_W'($urandom_range(255)));
        if (pick < 35) begin
            rq.key = fresh_key();
        end else if (pick < 55) begin
            // Rewrite a stored key.
            if (entry_count > 0) rq.key = key_tbl[$urandom_range(entry_count - 1)];
        end else if (pick < 80) begin
            rq.req_type = REQ_LOOKUP;
            if (entry_count > 0) begin
                rq.dispatch_index = DISP_W'($urandom_range(entry_count - 1));
            end
        end else if (pick < 90) begin
            rq.req_type = REQ_LOOKUP;
        end else if (pick < 95) begin
            rq.req_type = REQ_CLEAR;
        end else begin
            rq.req_type = REQ_UNKNOWN;
        end
        send_request(rq);
    endtask

    // Empty table: every lookup is out of range, a clear still replies, and an
    // unknown request type is dropped.
    task automatic test_empty_table();
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd0));
        send_request(make_request(REQ_LOOKUP, '1, '1, '1, 8'd255));
        send_request(make_request(REQ_CLEAR, '0, '0, '0, '0));
        send_request(make_request(REQ_UNKNOWN, '1, '1, '1, '1));
    endtask

    // Largest key first, then the smallest (shifts it up), then one in between.
    task automatic test_insert_extremes();
        send_request(make_request(REQ_INSERT, '1, '1, '1, '0));
        send_request(make_request(REQ_INSERT, '0, '0, '0, '1));
        send_request(make_request(REQ_INSERT, 32'h8000_0000, 32'd1, 16'd1, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd1));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd2));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd3));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd255));
    endtask

    // Rewrite stored keys: one slot goes active, one goes inactive but still
    // returns its new runtime index, and one stays active.
    task automatic test_update_existing();
        send_request(make_request(REQ_INSERT, '0, 32'hDEAD_BEEF, 16'h5A5A, '0));
        send_request(make_request(REQ_INSERT, '1, '0, 16'h1234, '0));
        send_request(make_request(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd1));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd2));
    endtask

    // Clear keeps the keys: slots read back inactive, then one key refills.
    task automatic test_clear_slots();
        send_request(make_request(REQ_CLEAR, '1, '1, '1, '1));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd2));
        send_request(make_request(REQ_INSERT, 32'h8000_0000, 32'h0000_0001, 16'hFFFF, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd2));
    endtask

    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random_request();
    endtask

    // Stall the reply side for a long stretch while requests keep coming, so the
    // output register and the finished result back up into the request side.
    task automatic test_output_backpressure();
        send_idle_pct   = 0;
        rsp_hold_cycles = 400;
        repeat (24) send_random_request();
    endtask

    // Pause the request side until every reply is in, then resume.
    task automatic test_pause_for_replies();
        repeat (8) send_random_request();
        idle_until_replies_done();
        repeat (8) send_random_request();
    endtask

    // Fill the table to capacity, then hit it with misses, updates and the top slot.
    task automatic test_full_table();
        logic [KEYIN_W-1:0] key;
        while (entry_count < TABLE_DEPTH) begin
            do key = fresh_key(); while (key_present(key));
            send_request(make_request(REQ_INSERT, key, random_handle(),
                                      RUNTIME_W'($urandom_range(16'hFFFF)),
                                      DISP_W'($urandom_range(255))));
        end
        repeat (4) begin
            do key = $urandom(); while (key_present(key));
            send_request(make_request(REQ_INSERT, key, $urandom(),
                                      RUNTIME_W'($urandom_range(16'hFFFF)),
                                      DISP_W'($urandom_range(255))));
        end
        send_request(make_request(REQ_INSERT, key_tbl[0], '1, '1, '0));
        send_request(make_request(REQ_INSERT, key_tbl[TABLE_DEPTH - 1], '0, 16'hABCD, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd255));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, slot_tbl[0]));
        send_request(make_request(REQ_CLEAR, '0, '0, '0, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, 8'd255));
    endtask

    initial begin
        error_count     = 0;
        entry_count     = 0;
        rsp_hold_cycles = 0;
        send_idle_pct   = 34;
        recv_idle_pct   = 65;

        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_INSERT;
        req_ch.key            <= '0;
        req_ch.func_handle    <= '0;
        req_ch.rt_index       <= '0;
        req_ch.dispatch_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_insert_extremes();
        test_update_existing();
        test_clear_slots();
        test_random_mix(350, 34, 65);
        test_output_backpressure();
        test_pause_for_replies();
        test_random_mix(350, 65, 34);
        test_full_table();
        test_random_mix(300, 0, 0);

        // Let the last word drain, then watch a while for stray replies.
        idle_until_replies_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/skt_pkg.sv
src/skt_req_if.sv
src/skt_rsp_if.sv
src/skt_ram.sv
src/skt_ctrl.sv
src/skt_dp.sv
src/sorted_key_table_stable_index.sv
sim/sorted_key_table_stable_index_test.sv
